>>> rtl/bm3_pkg.sv
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types and constants for the 3x3 binary morphology core.
// ----------------------------------------------------------------------------
package bm3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int OUT_ROW_W      = 12;
    localparam int OUT_COL_W      = 10;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 24;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 4;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd1024;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_MODE         = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_addr_t;

    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    // Where the current pixel sits in the frame.
    typedef struct packed {
        logic row_first;
        logic row_one;
        logic row_last;
        logic col_first;
        logic col_one;
        logic col_last;
    } pos_flags_t;

    // Results caused by one pixel: up to two rows by two columns.
    typedef struct packed {
        logic [3:0] pix;
        logic       two_rows;
        logic       two_cols;
    } slot_set_t;

endpackage

>>> rtl/binary_morphology_3x3_core.sv
// ----------------------------------------------------------------------------
// binary_morphology_3x3_core
// Streaming 3x3 dilation or erosion of black on a binary raster image, with
// a line store of the two previous rows.
// ----------------------------------------------------------------------------
// The first result of an accepted pixel is valid after the line store read
// and then the output register. Throughput: one pixel per cycle while each
// pixel gives at most one result and m_axis_tready is high; the output port
// carries one result per cycle, so a pixel at the right column or in the
// last row holds the input until its further results are taken.
// Reset: counters, window and handshakes clear, mode 0 and 1024x1024; the
// line store is not cleared, since each entry is written before it is used.
module binary_morphology_3x3_core #(
    parameter int MAX_WIDTH  = bm3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bm3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bm3_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bm3_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bm3_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: [0] pixel_in, [7:1] zero
    input  logic [bm3_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: [0] pixel_out, [12:1] out_row, [22:13] out_col, [23] zero
    output logic [bm3_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import bm3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic                      mode_reg;
    logic [FRAME_WIDTH_W-1:0]  fw_reg;
    logic [FRAME_HEIGHT_W-1:0] fh_reg;
    logic                      cfg_we;
    cfg_addr_t                 cfg_addr;

    logic [CW-1:0] wlast;
    logic [RW-1:0] hlast;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] c_eff;
    logic [RW-1:0] r_eff;
    logic          in_accept;

    logic          a_valid_reg;
    logic          a_valid_next;
    logic          a_px_reg;
    logic [CW-1:0] a_col_reg;
    logic [RW-1:0] a_row_reg;
    pos_flags_t    a_flags_reg;
    pos_flags_t    flags_now;
    logic          a_adv;

    logic [1:0]    line_q;
    logic [1:0]    line_d;
    logic [3:0]    slot_pix;
    slot_set_t     slots;
    logic          has_result;
    logic          emit_load;
    logic          emit_free;
    logic [RW-1:0] row_base;
    logic [CW-1:0] col_base;
    logic          out_pixel;
    logic [RW-1:0] out_row;
    logic [CW-1:0] out_col;

    // Configuration port
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign cfg_addr = cfg_addr_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DILATE;
            fw_reg   <= FRAME_WIDTH_RST;
            fh_reg   <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MODE:         mode_reg <= pwdata[0];
                REG_FRAME_WIDTH:  fw_reg   <= pwdata[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: fh_reg   <= pwdata[FRAME_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_addr)
            REG_MODE:         prdata = APB_DATA_W'(mode_reg);
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(fw_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(fh_reg);
            default:          prdata = '0;
        endcase
    end

    // Last column and row of the frame, with the size clamped to 1..MAX.
    assign wlast = (fw_reg == '0) ? '0 :
                   (32'(fw_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : CW'(fw_reg - 1'b1);
    assign hlast = (fh_reg == '0) ? '0 :
                   (32'(fh_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT - 1) : RW'(fh_reg - 1'b1);

    // A counter beyond a reduced frame size counts as the last column or row.
    assign c_eff = (col_reg > wlast) ? wlast : col_reg;
    assign r_eff = (row_reg > hlast) ? hlast : row_reg;

    assign flags_now.row_first = (r_eff == '0);
    assign flags_now.row_one   = (r_eff == RW'(1));
    assign flags_now.row_last  = (r_eff == hlast);
    assign flags_now.col_first = (c_eff == '0);
    assign flags_now.col_one   = (c_eff == CW'(1));
    assign flags_now.col_last  = (c_eff == wlast);

    assign a_adv         = a_valid_reg && emit_free;
    assign s_axis_tready = !a_valid_reg || a_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (flags_now.col_last)
            begin
                col_next = '0;
                row_next = flags_now.row_last ? '0 : r_eff + 1'b1;
            end
            else
            begin
                col_next = c_eff + 1'b1;
                row_next = r_eff;
            end
        end
        priority if (in_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_px_reg    <= s_axis_tdata[0];
            a_col_reg   <= c_eff;
            a_row_reg   <= r_eff;
            a_flags_reg <= flags_now;
        end
    end

    bm3_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (c_eff),
        .wr_en   (a_adv),
        .wr_addr (a_col_reg),
        .wr_data (line_d),
        .rd_data (line_q)
    );

    bm3_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (a_adv),
        .mode     (mode_reg),
        .px       (a_px_reg),
        .flags    (a_flags_reg),
        .line_q   (line_q),
        .line_d   (line_d),
        .slot_pix (slot_pix)
    );

    // The first row or column of a frame completes nothing unless it is also the last.
    assign has_result = (!a_flags_reg.row_first || a_flags_reg.row_last) &&
                        (!a_flags_reg.col_first || a_flags_reg.col_last);
    assign emit_load  = a_adv && has_result;

    assign slots.pix      = slot_pix;
    assign slots.two_rows = !a_flags_reg.row_first && a_flags_reg.row_last;
    assign slots.two_cols = !a_flags_reg.col_first && a_flags_reg.col_last;
    assign row_base = a_flags_reg.row_first ? a_row_reg : a_row_reg - 1'b1;
    assign col_base = a_flags_reg.col_first ? a_col_reg : a_col_reg - 1'b1;

    bm3_emit #(
        .CW (CW),
        .RW (RW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .slots     (slots),
        .row_base  (row_base),
        .col_base  (col_base),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_pixel (out_pixel),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_axis_tlast),
        .free      (emit_free)
    );

    assign m_axis_tdata = {1'b0, OUT_COL_W'(out_col), OUT_ROW_W'(out_row), out_pixel};

    // The counters wrap to the origin after the last pixel of a frame.
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && flags_now.col_last && flags_now.row_last)
            |=> (col_reg == '0 && row_reg == '0))
        else $error("position counters did not wrap at the end of a frame");

    // The output register is loaded only once its last result is taken.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
        else $error("result set loaded over pending results");

    // After the last result of a set goes out with nothing new, output goes idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !emit_load) |=> !m_axis_tvalid)
        else $error("output still valid after the last result of a set");

endmodule

>>> rtl/bm3_line_store.sv
// ----------------------------------------------------------------------------
// bm3_line_store
// Line store for the two previous rows, one 2-bit entry per column, with a
// synchronous read and forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module bm3_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [1:0]               wr_data,
    output logic [1:0]               rd_data
);
    import bm3_pkg::*;

    // Bit 1 holds the row two above, bit 0 the row one above.
    logic [1:0] mem [DEPTH];
    logic [1:0] mem_q_reg;
    logic [1:0] fwd_data_reg;
    logic       fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read that meets a write to the same entry sees the old value,
    // so the new value is kept aside and used instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

>>> rtl/bm3_window.sv
// ----------------------------------------------------------------------------
// bm3_window
// 3x3 window register and the morphology kernel for the up to four output
// pixels that one input pixel completes.
// ----------------------------------------------------------------------------
module bm3_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                mode,
    input  logic                px,
    input  bm3_pkg::pos_flags_t flags,
    input  logic [1:0]          line_q,
    output logic [1:0]          line_d,
    output logic [3:0]          slot_pix
);
    import bm3_pkg::*;

    logic [8:0] win_reg;
    logic [8:0] win_next;

    // Row k of the window sits at bits 3k..3k+2, the newest column on top.
    assign win_next = {px, win_reg[8:7], line_q[0], win_reg[5:4], line_q[1], win_reg[2:1]};
    assign line_d   = {line_q[0], px};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (adv)
        begin
            win_reg <= win_next;
        end
    end

    function automatic logic morph_slot(
        input logic [8:0] win,
        input pos_flags_t f,
        input logic       ri,
        input logic       ci,
        input logic       md
    );
        logic [1:0]  cr;
        logic [1:0]  cc;
        logic        top_ok;
        logic        bot_ok;
        logic        lft_ok;
        logic        rgt_ok;
        logic        any_black;
        logic        any_white;
        logic        use_bit;
        logic [2:0]  wr;
        logic [2:0]  wc;
        logic [3:0]  idx;
        logic [15:0] wpad;
        cr = (f.row_first || ri) ? 2'd2 : 2'd1;
        cc = (f.col_first || ci) ? 2'd2 : 2'd1;
        top_ok = !(f.row_first || (!ri && f.row_one));
        bot_ok = !((cr == 2'd2) && f.row_last);
        lft_ok = !(f.col_first || (!ci && f.col_one));
        rgt_ok = !((cc == 2'd2) && f.col_last);
        wpad = {7'h7f, win};
        any_black = 1'b0;
        any_white = 1'b0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                wr = 3'(cr) + 3'(dr) - 3'd1;
                wc = 3'(cc) + 3'(dc) - 3'd1;
                idx = 4'(wr) * 4'd3 + 4'(wc);
                use_bit = (dr != 0 || top_ok) && (dr != 2 || bot_ok) &&
                          (dc != 0 || lft_ok) && (dc != 2 || rgt_ok) &&
                          (wr <= 3'd2) && (wc <= 3'd2);
                if (use_bit)
                begin
                    if (wpad[idx])
                    begin
                        any_white = 1'b1;
                    end
                    else
                    begin
                        any_black = 1'b1;
                    end
                end
            end
        end
        return (md == MODE_DILATE) ? !any_black : any_white;
    endfunction

    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            slot_pix[s] = morph_slot(win_next, flags, s[1], s[0], mode);
        end
    end

endmodule

>>> rtl/bm3_emit.sv
// ----------------------------------------------------------------------------
// bm3_emit
// Output register that holds the results of one pixel and hands them out
// one per cycle while out_ready is high, in raster order.
// ----------------------------------------------------------------------------
module bm3_emit #(
    parameter int CW = 10,
    parameter int RW = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  bm3_pkg::slot_set_t  slots,
    input  logic [RW-1:0]       row_base,
    input  logic [CW-1:0]       col_base,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_pixel,
    output logic [RW-1:0]       out_row,
    output logic [CW-1:0]       out_col,
    output logic                out_last,
    output logic                free
);
    import bm3_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    slot_set_t     slots_reg;
    logic [RW-1:0] row_base_reg;
    logic [CW-1:0] col_base_reg;
    logic          ri_reg;
    logic          ri_next;
    logic          ci_reg;
    logic          ci_next;
    logic          take;

    assign out_last  = (ri_reg == slots_reg.two_rows) && (ci_reg == slots_reg.two_cols);
    assign take      = valid_reg && out_ready;
    assign free      = !valid_reg || (out_ready && out_last);
    assign out_valid = valid_reg;
    assign out_pixel = slots_reg.pix[{ri_reg, ci_reg}];
    assign out_row   = row_base_reg + RW'(ri_reg);
    assign out_col   = col_base_reg + CW'(ci_reg);

    always_comb
    begin
        valid_next = valid_reg;
        ri_next    = ri_reg;
        ci_next    = ci_reg;
        priority if (load)
        begin
            valid_next = 1'b1;
            ri_next    = 1'b0;
            ci_next    = 1'b0;
        end
        else if (take)
        begin
            if (out_last)
            begin
                valid_next = 1'b0;
            end
            else if (ci_reg != slots_reg.two_cols)
            begin
                ci_next = 1'b1;
            end
            else
            begin
                ci_next = 1'b0;
                ri_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ri_reg    <= 1'b0;
            ci_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ri_reg    <= ri_next;
            ci_reg    <= ci_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slots_reg    <= slots;
            row_base_reg <= row_base;
            col_base_reg <= col_base;
        end
    end

endmodule
